/* design/dvru_pkg.sv */
package dvru_pkg;

  // Sizes fixed by the advertisement format
  localparam int unsigned DVRU_TABLE_ENTRIES = 64;
  localparam int unsigned ADDR_W             = 32;
  localparam int unsigned METRIC_W           = 5;
  localparam int unsigned PORT_W             = 4;
  localparam int unsigned SLOT_W             = 6;
  localparam int unsigned ACT_W              = 3;
  localparam int unsigned IN_TDATA_W         = 112;
  localparam int unsigned OUT_TDATA_W        = 16;

  // Metric of an unreachable route
  localparam logic [METRIC_W-1:0] METRIC_INF = 5'd16;

  // Action codes reported per item
  typedef enum logic [ACT_W-1:0] {
    ACT_ADDED     = 3'd0,
    ACT_DROPPED   = 3'd1,
    ACT_WITHDRAWN = 3'd2,
    ACT_REPLACED  = 3'd3,
    ACT_REFRESHED = 3'd4,
    ACT_WORSE     = 3'd5,
    ACT_FULL      = 3'd6,
    ACT_DISABLED  = 3'd7
  } dvru_act_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } dvru_state_t;

  // One received advertisement
  typedef struct packed {
    logic [PORT_W-1:0]   arrival_port;
    logic [ADDR_W-1:0]   sender_addr;
    logic [METRIC_W-1:0] adv_metric;
    logic [ADDR_W-1:0]   dest_mask;
    logic [ADDR_W-1:0]   dest_addr;
  } dvru_item_t;

  // One result
  typedef struct packed {
    logic [METRIC_W-1:0] stored_metric;
    logic [SLOT_W-1:0]   slot;
    dvru_act_t           action;
  } dvru_result_t;

  // One table word; the mask is accepted but never read back, so it is not kept
  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   dest;
    logic [METRIC_W-1:0] metric;
    logic [ADDR_W-1:0]   gateway;
    logic [PORT_W-1:0]   port;
  } dvru_entry_t;

endpackage

/* design/distance_vector_route_update_core.sv */
// Flow: an accepted item scans the table one entry per cycle, then passes through the DRAIN
//   and DECIDE states before m_axis_tvalid is registered; a disabled item goes straight to DECIDE.
// Items: one item is in work at a time, set by the scan of the table memory read port;
//   the next item is taken while a result waits.
// Reset: synchronous; enable returns to 1, then a clearing pass writes every entry invalid
//   with s_axis_tready low.
module distance_vector_route_update_core #(
  parameter int unsigned TABLE_ENTRIES = dvru_pkg::DVRU_TABLE_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // dest_addr[31:0], dest_mask[63:32], adv_metric[68:64], sender_addr[100:69],
  // arrival_port[104:101], zero fill above
  input  logic [dvru_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // action[2:0], slot[8:3], stored_metric[13:9], zero fill above
  output logic [dvru_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import dvru_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  logic          enable;
  dvru_item_t    in_item;
  dvru_result_t  out_result;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  dvru_entry_t   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  dvru_entry_t   rd_data;

  // enable register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable <= cfg_data;
    end
  end

  // unpack the item, pack the result
  assign in_item.dest_addr    = s_axis_tdata[31:0];
  assign in_item.dest_mask    = s_axis_tdata[63:32];
  assign in_item.adv_metric   = s_axis_tdata[68:64];
  assign in_item.sender_addr  = s_axis_tdata[100:69];
  assign in_item.arrival_port = s_axis_tdata[104:101];
  assign m_axis_tdata = {2'b00, out_result.stored_metric, out_result.slot,
                         out_result.action};

  dvru_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AW           (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .enable    (enable),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_result(out_result),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  dvru_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AW           (AW)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

/* design/dvru_table.sv */
module dvru_table #(
  parameter int unsigned TABLE_ENTRIES = dvru_pkg::DVRU_TABLE_ENTRIES,
  parameter int unsigned AW            = $clog2(TABLE_ENTRIES)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  dvru_pkg::dvru_entry_t wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output dvru_pkg::dvru_entry_t rd_data
);
  import dvru_pkg::*;

  dvru_entry_t mem [TABLE_ENTRIES];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/dvru_ctrl.sv */
module dvru_ctrl #(
  parameter int unsigned TABLE_ENTRIES = dvru_pkg::DVRU_TABLE_ENTRIES,
  parameter int unsigned AW            = $clog2(TABLE_ENTRIES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   enable,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dvru_pkg::dvru_item_t   in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dvru_pkg::dvru_result_t out_result,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output dvru_pkg::dvru_entry_t  wr_data,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  dvru_pkg::dvru_entry_t  rd_data
);
  import dvru_pkg::*;

  dvru_state_t         state, state_next;
  logic [AW-1:0]       cnt;
  logic                cnt_last;
  logic                accept;
  logic                out_free;

  // item under work
  dvru_item_t          item;
  logic [METRIC_W-1:0] metric;
  logic                item_en;

  // scan tracking
  logic                pend_valid;
  logic [AW-1:0]       pend_idx;
  logic                found_hit;
  logic [AW-1:0]       found_idx;
  logic [METRIC_W-1:0] hit_metric;
  logic [ADDR_W-1:0]   hit_gw;
  logic                free_hit;
  logic [AW-1:0]       free_idx;

  // decision
  dvru_act_t           act;
  logic [AW-1:0]       act_idx;
  logic                act_slot;
  logic                act_wr;
  dvru_entry_t         act_word;
  logic [METRIC_W-1:0] metric_in;

  assign cnt_last = (cnt == AW'(TABLE_ENTRIES - 1));
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // clamp the received metric to 16, then count the hop
  assign metric_in = (in_item.adv_metric > METRIC_INF) ?
                     METRIC_INF + 5'd1 : in_item.adv_metric + 5'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (cnt_last) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = enable ? ST_SCAN : ST_DECIDE;
      ST_SCAN:   if (cnt_last) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_DECIDE;
      ST_DECIDE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // route decision from the scan outcome
  always_comb begin
    act      = ACT_DISABLED;
    act_idx  = found_idx;
    act_slot = 1'b0;
    act_wr   = 1'b0;
    act_word = '{valid: 1'b1, dest: item.dest_addr, metric: metric,
                 gateway: item.sender_addr, port: item.arrival_port};
    if (!item_en) begin
      act = ACT_DISABLED;
    end else if (!found_hit) begin
      if (metric >= METRIC_INF) begin
        act = ACT_DROPPED;
      end else if (!free_hit) begin
        act = ACT_FULL;
      end else begin
        act      = ACT_ADDED;
        act_idx  = free_idx;
        act_slot = 1'b1;
        act_wr   = 1'b1;
      end
    end else begin
      act_slot = 1'b1;
      if (metric >= METRIC_INF) begin
        act            = ACT_WITHDRAWN;
        act_wr         = 1'b1;
        act_word.valid = 1'b0;
      end else if (hit_metric > metric ||
                   (hit_gw == item.sender_addr && hit_metric != metric)) begin
        act    = ACT_REPLACED;
        act_wr = 1'b1;
      end else if (hit_metric == metric) begin
        act = ACT_REFRESHED;
      end else begin
        act = ACT_WORSE;
      end
    end
  end

  // memory and handshake outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    rd_en    = (state == ST_SCAN);
    rd_addr  = cnt;
    wr_en    = 1'b0;
    wr_addr  = cnt;
    wr_data  = '0;
    case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_DECIDE: begin
        wr_en   = act_wr && out_free;
        wr_addr = act_idx;
        wr_data = act_word;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == ST_SCAN);
      if (state == ST_CLEAR || state == ST_SCAN) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
      if (state == ST_DECIDE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item capture, scan compare and result register
  always_ff @(posedge clk) begin
    pend_idx <= cnt;
    if (accept) begin
      item      <= in_item;
      metric    <= metric_in;
      item_en   <= enable;
      found_hit <= 1'b0;
      free_hit  <= 1'b0;
    end else if (pend_valid) begin
      if (rd_data.valid) begin
        if (!found_hit && rd_data.dest == item.dest_addr) begin
          found_hit  <= 1'b1;
          found_idx  <= pend_idx;
          hit_metric <= rd_data.metric;
          hit_gw     <= rd_data.gateway;
        end
      end else if (!free_hit) begin
        free_hit <= 1'b1;
        free_idx <= pend_idx;
      end
    end
    if (state == ST_DECIDE && out_free) begin
      out_result.action        <= act;
      out_result.slot          <= act_slot ? SLOT_W'(act_idx) : '0;
      out_result.stored_metric <= metric;
    end
  end

endmodule

/* design/dvru_checker.sv */
module dvru_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import dvru_pkg::*;

  // reset starts the clearing pass, so no item is taken right after it
  a_reset_blocks: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("item taken right after reset");

  // one item at a time: an accept closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // an added route is always reachable
  a_added_reach: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == ACT_ADDED |-> m_axis_tdata[13:9] < METRIC_INF)
    else $error("unreachable route added");

  // no slot is reported when none was touched
  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[2:0] == ACT_DROPPED || m_axis_tdata[2:0] == ACT_FULL ||
                      m_axis_tdata[2:0] == ACT_DISABLED) |-> m_axis_tdata[8:3] == '0)
    else $error("slot reported without a table entry");

endmodule

bind distance_vector_route_update_core dvru_checker u_dvru_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
